// File: src/dmtf_pkg.sv
package dmtf_pkg;

   localparam int MaxLineDefault = 512;

   localparam int InByteWidth  = 8;
   localparam int OutByteWidth = 7;

   // ASCII codes the filter looks at, all on stripped (7-bit) bytes
   localparam logic [6:0] ChrSoftHyphen = 7'h1F;
   localparam logic [6:0] ChrHardSpace  = 7'h0F;
   localparam logic [6:0] ChrCr         = 7'h0D;
   localparam logic [6:0] ChrLf         = 7'h0A;
   localparam logic [6:0] ChrFf         = 7'h0C;
   localparam logic [6:0] ChrTab        = 7'h09;
   localparam logic [6:0] ChrDot        = 7'h2E;
   localparam logic [6:0] ChrDash       = 7'h2D;
   localparam logic [6:0] ChrSpace      = 7'h20;

   // raw (8-bit) codes seen inside a dot-command line
   localparam logic [7:0] RawLf     = 8'h0A;
   localparam logic [7:0] RawUpperP = 8'h50;
   localparam logic [7:0] RawUpperA = 8'h41;
   localparam logic [7:0] RawLowerP = 8'h70;
   localparam logic [7:0] RawLowerA = 8'h61;

endpackage

// File: src/document_mode_text_filter_unit.sv
// Channel   Dir  tdata (low bit up)             tuser  tlast
// req_      in   [7:0] in_byte                  -      -
// rsp_      out  [6:0] out_byte, [7] zero pad   -      -
//
// One byte per cycle while rsp_ is not stalled: a beat accepted at one edge is
// decoded in a single pass against the line flags and its result (if any) sits
// in the output register from the next cycle on.
// req_tready is high while the output register is empty or being taken, so a
// stalled rsp_ side stops intake once the output register holds a byte; no beat is lost or repeated.
// Beats that give no output (CR, dropped control bytes, dot-line bytes but
// a page line's closing FF) update only the flags and empty the output register.
// reset (synchronous, active high) returns to start of line, outside any
// dot-command line, with the output register empty.
module document_mode_text_filter_unit
   import dmtf_pkg::*;
#(
   parameter int MAX_LINE = MaxLineDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [6:0] out_byte, [7] zero
);

   localparam int LEN_W = $clog2(MAX_LINE);
   localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
   localparam logic [LEN_W-1:0] LEN_TWO = LEN_W'(2);
   localparam logic [LEN_W-1:0] LEN_END = LEN_W'(MAX_LINE - 1);

   // line-tracking state
   logic             at_line_start_ff, at_line_start_in;
   logic             in_dot_ff, in_dot_in;
   logic [LEN_W-1:0] dot_len_ff, dot_len_in;
   logic [7:0]       dot_first_ff, dot_first_in;
   logic             dot_hit_ff, dot_hit_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [6:0]       rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             emit;
   logic [6:0]       emit_byte;
   logic [7:0]       raw;
   logic [6:0]       chr;
   logic [LEN_W-1:0] len_next;
   logic             hit_next;
   logic             dot_end;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign raw        = req_tdata;
   assign chr        = raw[6:0];

   // dot-command line bookkeeping
   assign len_next = dot_len_ff + LEN_ONE;
   assign hit_next = (len_next == LEN_TWO)
                   ? ((dot_first_ff == RawUpperP && raw == RawUpperA) ||
                      (dot_first_ff == RawLowerP && raw == RawLowerA))
                   : dot_hit_ff;
   assign dot_end  = (raw == RawLf) || (len_next >= LEN_END);

   always_comb begin
      at_line_start_in = at_line_start_ff;
      in_dot_in        = in_dot_ff;
      dot_len_in       = dot_len_ff;
      dot_first_in     = dot_first_ff;
      dot_hit_in       = dot_hit_ff;
      emit             = 1'b0;
      emit_byte        = chr;

      if (in_dot_ff) begin
         // raw bytes, swallowed until LF or the length limit
         if (dot_end) begin
            in_dot_in        = 1'b0;
            dot_len_in       = '0;
            dot_first_in     = '0;
            dot_hit_in       = 1'b0;
            at_line_start_in = 1'b1;
            emit             = hit_next;
            emit_byte        = ChrFf;
         end else begin
            dot_len_in = len_next;
            dot_hit_in = hit_next;
            if (len_next == LEN_ONE) begin
               dot_first_in = raw;
            end
         end
      end else if (at_line_start_ff && chr == ChrDot) begin
         in_dot_in    = 1'b1;
         dot_len_in   = '0;
         dot_first_in = '0;
         dot_hit_in   = 1'b0;
      end else if (at_line_start_ff && chr == ChrLf) begin
         // LF at line start keeps line start
         emit = 1'b1;
      end else begin
         at_line_start_in = 1'b0;
         if (chr < ChrSpace) begin
            unique case (chr)
               ChrSoftHyphen: begin
                  emit      = 1'b1;
                  emit_byte = ChrDash;
               end
               ChrHardSpace: begin
                  emit      = 1'b1;
                  emit_byte = ChrSpace;
               end
               ChrLf, ChrFf, ChrTab: begin
                  emit = 1'b1;
               end
               ChrCr: begin
                  at_line_start_in = 1'b1;
               end
               default: begin
                  emit = 1'b0;
               end
            endcase
         end else begin
            emit = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = emit;
         rsp_data_in  = emit_byte;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_line_start_ff <= 1'b1;
         in_dot_ff        <= 1'b0;
         dot_len_ff       <= '0;
         dot_first_ff     <= '0;
         dot_hit_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            at_line_start_ff <= at_line_start_in;
            in_dot_ff        <= in_dot_in;
            dot_len_ff       <= dot_len_in;
            dot_first_ff     <= dot_first_in;
            dot_hit_ff       <= dot_hit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

`ifndef SYNTHESIS
   a_len_idle: assert property (@(posedge clock) disable iff (reset)
      !in_dot_ff |-> (dot_len_ff == '0 && !dot_hit_ff))
      else $error("dot line counters not cleared outside a dot line");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      dot_len_ff < LEN_END)
      else $error("dot line length passed its limit");

   a_hit_len: assert property (@(posedge clock) disable iff (reset)
      dot_hit_ff |-> dot_len_ff >= LEN_TWO)
      else $error("page hit flagged before two bytes");

   a_dot_out: assert property (@(posedge clock) disable iff (reset)
      (accept && in_dot_ff) |=> (!rsp_valid_ff || rsp_data_ff == ChrFf))
      else $error("dot line beat gave a byte other than FF");
`endif

endmodule
